// ===== src/bpts_pkg.sv =====
// ============================================================================
// Byte-level pre-token splitter: shared package
// Types, constants and small helper functions used across the splitter.
// ============================================================================
`default_nettype none

package bpts_pkg;

    localparam int MAX_SEGMENT_BYTES = 65535;
    localparam int LOOKAHEAD_BYTES   = 17;
    // The newest byte of a full window is the incoming one, so one cell fewer.
    localparam int WIN_CELLS         = LOOKAHEAD_BYTES - 1;
    localparam int POS_LIMIT = (MAX_SEGMENT_BYTES < 65535) ? MAX_SEGMENT_BYTES : 65535;
    localparam int POS_CAP   = POS_LIMIT + 64;
    localparam int POS_W     = $clog2(POS_CAP + 1);
    localparam int FILL_W    = $clog2(LOOKAHEAD_BYTES);
    localparam int IDX_W     = $clog2(WIN_CELLS);
    localparam int OQ_DEPTH  = 4;
    localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

    localparam logic [LOOKAHEAD_BYTES*8-1:0] SPLIT_LIT = "SPL1T-TH1S-Pl3A5E";
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       segment_end;
    } t_text;

    typedef struct packed {
        logic [15:0] piece_offset;
        logic [15:0] piece_length;
        logic        piece_last;
        logic        length_overflow;
    } t_piece;

    typedef enum logic [2:0] {
        CL_NONE   = 3'd0,
        CL_SINGLE = 3'd1,
        CL_PUNCT  = 3'd2,
        CL_LETTER = 3'd3,
        CL_OTHER  = 3'd4,
        CL_SPACE  = 3'd5
    } t_cls;

    typedef enum logic [1:0] {
        EV_BYTE  = 2'd0,
        EV_CLOSE = 2'd1,
        EV_FINAL = 2'd2
    } t_evt_kind;

    typedef enum logic {
        S_RUN   = 1'b0,
        S_FLUSH = 1'b1
    } t_seq_state;

    typedef struct packed {
        t_evt_kind  kind;
        logic [7:0] ch;
        t_pos       pos;
        logic       ovf;
        logic       end_step;
    } t_evt;

    typedef struct packed {
        logic [1:0] num;
        t_piece     item1;
        t_piece     item0;
    } t_push;

    function automatic t_cls byte_kind(input logic [7:0] c);
        logic [7:0] lc;
        t_cls       k;
        lc = c | 8'h20;
        if ((c >= "0" && c <= "9") || c == "(" || c == ")" || c == "[" ||
            c == "]" || c == "{" || c == "}" || c == 8'h0A) begin
            k = CL_SINGLE;
        end else if (c == "!" || c == 8'h22 || c == "#" || c == "$" || c == "%" ||
                     c == "&" || c == 8'h27 || c == "*" || c == "+" || c == "," ||
                     c == "-" || c == "." || c == "/" || c == ":" || c == ";" ||
                     c == "<" || c == "=" || c == ">" || c == "?" || c == 8'h5C ||
                     c == "^" || c == "_" || c == 8'h60 || c == "|" || c == "~") begin
            k = CL_PUNCT;
        end else if (lc >= "a" && lc <= "z") begin
            k = CL_LETTER;
        end else if (c == CH_SPACE || c == 8'h09 || c == 8'h0B || c == 8'h0C ||
                     c == 8'h0D) begin
            k = CL_SPACE;
        end else begin
            k = CL_OTHER;
        end
        return k;
    endfunction

    function automatic t_pos clamp_pos(input t_pos p);
        return (p > POS_W'(POS_LIMIT)) ? POS_W'(POS_LIMIT) : p;
    endfunction

    function automatic t_piece mk_piece(input t_pos s, input t_pos e, input logic ovf);
        t_pos   cs;
        t_pos   ce;
        t_piece r;
        cs = clamp_pos(s);
        ce = clamp_pos(e);
        r.piece_offset    = 16'(cs);
        r.piece_length    = (ce > cs) ? 16'(ce - cs) : 16'd0;
        r.piece_last      = 1'b0;
        r.length_overflow = ovf;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/bpts_cell.sv =====
// ============================================================================
// Lookahead window cell
// Holds one pending byte, passes it on when the window shifts, and compares
// it against the literal character for its place.
// ============================================================================
`default_nettype none

module bpts_cell (
    input  wire logic       i_clk,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_lit,
    output logic      [7:0] o_byte,
    output logic            o_match
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte  = r_byte;
    assign o_match = (r_byte == i_lit);

endmodule

`default_nettype wire

// ===== src/bpts_piece.sv =====
// ============================================================================
// Piece tracker
// Consumes window events, keeps the open piece and produces finished pieces.
// Pieces of a segment's final request pass through a hold register so that
// the last one can be marked.
// ============================================================================
`default_nettype none

module bpts_piece (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_ev_valid,
    input  wire bpts_pkg::t_evt i_ev,
    input  wire logic          i_space_ok,
    output logic               o_ev_take,
    output bpts_pkg::t_push    o_push
);

    bpts_pkg::t_cls   r_cls,    n_cls;
    bpts_pkg::t_pos   r_start,  n_start;
    logic [7:0]       r_prb,    n_prb;
    logic             r_pe,     n_pe;
    bpts_pkg::t_piece r_hold,   n_hold;
    logic             r_hold_v, n_hold_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls    <= bpts_pkg::CL_NONE;
            r_start  <= '0;
            r_prb    <= '0;
            r_pe     <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_cls    <= n_cls;
            r_start  <= n_start;
            r_prb    <= n_prb;
            r_pe     <= n_pe;
            r_hold_v <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

    always_comb begin
        bpts_pkg::t_cls   k;
        bpts_pkg::t_pos   p;
        bpts_pkg::t_pos   last;
        logic [1:0]       e_v;
        bpts_pkg::t_pos   s0, d0, s1, d1;
        bpts_pkg::t_piece q [3];
        logic [1:0]       qn;
        logic             final_ev;

        n_cls    = r_cls;
        n_start  = r_start;
        n_prb    = r_prb;
        n_pe     = r_pe;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        e_v      = 2'b00;
        s0 = '0; d0 = '0; s1 = '0; d1 = '0;
        p        = i_ev.pos;
        k        = bpts_pkg::byte_kind(i_ev.ch);
        last     = (p > r_start) ? p - 1'b1 : r_start;
        final_ev = 1'b0;
        o_ev_take = i_ev_valid && i_space_ok;
        o_push   = '0;
        q[0] = '0; q[1] = '0; q[2] = '0;
        qn = 2'd0;

        if (o_ev_take) begin
            unique case (i_ev.kind)
                bpts_pkg::EV_BYTE: begin
                    if ((r_cls == bpts_pkg::CL_PUNCT && k == bpts_pkg::CL_PUNCT &&
                         r_prb == i_ev.ch) ||
                        (r_cls == bpts_pkg::CL_LETTER && k == bpts_pkg::CL_LETTER) ||
                        (r_cls == bpts_pkg::CL_OTHER && k == bpts_pkg::CL_OTHER)) begin
                        // run continues
                    end else if (r_cls == bpts_pkg::CL_SPACE && k == bpts_pkg::CL_SPACE) begin
                        n_prb = i_ev.ch;
                    end else if (r_cls == bpts_pkg::CL_SPACE &&
                                 (k == bpts_pkg::CL_LETTER || k == bpts_pkg::CL_OTHER)) begin
                        // The whitespace run gives up its last byte.
                        if (last > r_start) begin
                            e_v[0] = 1'b1;
                            s0 = r_start;
                            d0 = last;
                        end
                        n_cls = k;
                        n_prb = 8'd0;
                        if (r_prb == bpts_pkg::CH_SPACE) begin
                            n_start = last;
                        end else begin
                            if (e_v[0]) begin
                                e_v[1] = 1'b1;
                                s1 = last;
                                d1 = p;
                            end else begin
                                e_v[0] = 1'b1;
                                s0 = last;
                                d0 = p;
                            end
                            n_start = p;
                        end
                    end else begin
                        if (r_cls != bpts_pkg::CL_NONE) begin
                            e_v[0] = 1'b1;
                            s0 = r_start;
                            d0 = p;
                        end
                        n_cls   = k;
                        n_start = p;
                        n_prb   = (k == bpts_pkg::CL_PUNCT || k == bpts_pkg::CL_SPACE) ?
                                  i_ev.ch : 8'd0;
                    end
                end
                bpts_pkg::EV_CLOSE: begin
                    if (r_cls != bpts_pkg::CL_NONE) begin
                        e_v[0] = 1'b1;
                        s0 = r_start;
                        d0 = p;
                    end
                    n_cls = bpts_pkg::CL_NONE;
                end
                bpts_pkg::EV_FINAL: begin
                    final_ev = 1'b1;
                    if (r_cls != bpts_pkg::CL_NONE) begin
                        e_v[0] = 1'b1;
                        s0 = r_start;
                        d0 = p;
                    end else if (!r_hold_v) begin
                        // Nothing came out of the final request: empty marker.
                        e_v[0] = 1'b1;
                        s0 = r_pe ? p : '0;
                        d0 = s0;
                    end
                end
                default: begin
                end
            endcase

            if (e_v != 2'b00) begin
                n_pe = 1'b1;
            end

            if (r_hold_v) begin
                q[qn] = r_hold;
                qn = qn + 2'd1;
            end
            if (e_v[0]) begin
                q[qn] = bpts_pkg::mk_piece(s0, d0, i_ev.ovf);
                qn = qn + 2'd1;
            end
            if (e_v[1]) begin
                q[qn] = bpts_pkg::mk_piece(s1, d1, i_ev.ovf);
                qn = qn + 2'd1;
            end

            if (final_ev) begin
                q[qn - 2'd1].piece_last = 1'b1;
                o_push.num   = qn;
                o_push.item0 = q[0];
                o_push.item1 = q[1];
                n_hold_v = 1'b0;
                n_cls    = bpts_pkg::CL_NONE;
                n_start  = '0;
                n_prb    = 8'd0;
                n_pe     = 1'b0;
            end else if (i_ev.end_step && qn != 2'd0) begin
                n_hold       = q[qn - 2'd1];
                n_hold_v     = 1'b1;
                o_push.num   = qn - 2'd1;
                o_push.item0 = q[0];
                o_push.item1 = q[1];
            end else begin
                o_push.num   = qn;
                o_push.item0 = q[0];
                o_push.item1 = q[1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/bpts_outq.sv =====
// ============================================================================
// Output queue
// Small piece queue that takes up to two pieces a cycle and hands out one.
// ============================================================================
`default_nettype none

module bpts_outq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bpts_pkg::t_push   i_push,
    output logic                   o_space_ok,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output bpts_pkg::t_piece       o_data
);

    bpts_pkg::t_piece                  r_mem [bpts_pkg::OQ_DEPTH];
    logic [bpts_pkg::OQ_PTR_W-1:0]     r_wp, r_rp;
    logic [bpts_pkg::OQ_CNT_W-1:0]     r_cnt, n_cnt;
    logic                              w_pop;

    assign o_valid    = (r_cnt != '0);
    assign o_data     = r_mem[r_rp];
    assign w_pop      = o_valid && i_ready;
    assign o_space_ok = (r_cnt <= bpts_pkg::OQ_CNT_W'(bpts_pkg::OQ_DEPTH - 2));
    assign n_cnt      = r_cnt + bpts_pkg::OQ_CNT_W'(i_push.num)
                      - bpts_pkg::OQ_CNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + bpts_pkg::OQ_PTR_W'(i_push.num);
            r_rp  <= r_rp + bpts_pkg::OQ_PTR_W'(w_pop);
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wp] <= i_push.item0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wp + 1'b1] <= i_push.item1;
        end
    end

endmodule

`default_nettype wire

// ===== src/byte_level_pretoken_splitter_top.sv =====
// ============================================================================
// Byte-level pre-token splitter
// Splits the bytes of a text segment into pre-token pieces (offset, length).
// ============================================================================
// Use: text bytes arrive as requests on the text channel (i_text_valid /
// o_text_ready), one byte per request, with segment_end set on the last byte
// of a segment. Pieces leave as requests on the piece channel
// (o_piece_valid / i_piece_ready); the final piece of a segment carries
// piece_last, and a segment that yields nothing gives one empty piece.
// Throughput is one byte per cycle while the piece channel keeps up and no
// flush runs. A byte enters a row of sixteen window cells, leaves it sixteen
// bytes later as a registered event, and its pieces pass through the piece
// queue. A request carrying segment_end is followed by a flush of the bytes
// still pending in the window and a closing step; no text is taken during it.
// The window literal is detected as the seventeenth byte arrives. The piece
// queue holds four pieces; when the receiver stalls it fills and the text
// channel is held off in turn, nothing being lost. After reset the block is
// empty and ready at once; every segment leaves it in that state.
// ============================================================================
`default_nettype none

module byte_level_pretoken_splitter_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_text_valid,
    output logic                  o_text_ready,
    input  wire bpts_pkg::t_text  i_text,
    output logic                  o_piece_valid,
    input  wire logic             i_piece_ready,
    output bpts_pkg::t_piece      o_piece
);

    // Window cells: index 0 holds the newest pending byte.
    logic [7:0] w_byte  [bpts_pkg::WIN_CELLS];
    logic       w_match [bpts_pkg::WIN_CELLS];
    logic       w_shift;
    logic       w_lit_hit;

    bpts_pkg::t_seq_state         r_state, n_state;
    logic [bpts_pkg::FILL_W-1:0]  r_fill,  n_fill;
    bpts_pkg::t_pos               r_pos,   n_pos;
    bpts_pkg::t_evt               r_ev,    n_ev;
    logic                         r_ev_v,  n_ev_v;

    logic            w_ev_take;
    logic            w_space_ok;
    bpts_pkg::t_push w_push;
    logic            w_accept;

    genvar gi;
    generate
        for (gi = 0; gi < bpts_pkg::WIN_CELLS; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                bpts_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_byte  (i_text.text_byte),
                    .i_lit   (bpts_pkg::SPLIT_LIT[8 +: 8]),
                    .o_byte  (w_byte[gi]),
                    .o_match (w_match[gi])
                );
            end else begin : g_body
                bpts_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_byte  (w_byte[gi-1]),
                    .i_lit   (bpts_pkg::SPLIT_LIT[(gi+1)*8 +: 8]),
                    .o_byte  (w_byte[gi]),
                    .o_match (w_match[gi])
                );
            end
        end
    endgenerate

    // The literal is seen when the window is one short and the incoming byte
    // completes it; each cell already compares with the character it would
    // hold in that case.
    always_comb begin
        w_lit_hit = (i_text.text_byte == bpts_pkg::SPLIT_LIT[7:0]);
        for (int j = 0; j < bpts_pkg::WIN_CELLS; j++) begin
            w_lit_hit = w_lit_hit && w_match[j];
        end
    end

    assign w_accept = i_text_valid && o_text_ready;
    assign w_shift  = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpts_pkg::S_RUN;
            r_fill  <= '0;
            r_pos   <= '0;
            r_ev_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pos   <= n_pos;
            r_ev_v  <= n_ev_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev <= n_ev;
    end

    always_comb begin
        logic                       slot_free;
        bpts_pkg::t_pos             pos_new;
        logic [bpts_pkg::IDX_W-1:0] idx;

        slot_free = !r_ev_v || w_ev_take;
        pos_new   = (r_pos < bpts_pkg::POS_W'(bpts_pkg::POS_CAP)) ? r_pos + 1'b1 : r_pos;
        idx       = bpts_pkg::IDX_W'(r_fill - 1'b1);

        n_state = r_state;
        n_fill  = r_fill;
        n_pos   = r_pos;
        n_ev    = r_ev;
        n_ev_v  = r_ev_v && !w_ev_take;
        o_text_ready = 1'b0;

        unique case (r_state)
            bpts_pkg::S_RUN: begin
                o_text_ready = slot_free;
                if (w_accept) begin
                    n_pos           = pos_new;
                    n_ev.ch         = w_byte[bpts_pkg::WIN_CELLS-1];
                    n_ev.pos        = pos_new - bpts_pkg::POS_W'(bpts_pkg::LOOKAHEAD_BYTES);
                    n_ev.ovf        = (pos_new > bpts_pkg::POS_W'(bpts_pkg::POS_LIMIT));
                    n_ev.end_step   = i_text.segment_end;
                    n_ev.kind       = bpts_pkg::EV_BYTE;
                    if (r_fill == bpts_pkg::FILL_W'(bpts_pkg::WIN_CELLS)) begin
                        n_ev_v = 1'b1;
                        if (w_lit_hit) begin
                            n_ev.kind = bpts_pkg::EV_CLOSE;
                            n_fill    = '0;
                        end
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                    if (i_text.segment_end) begin
                        n_state = bpts_pkg::S_FLUSH;
                    end
                end
            end
            bpts_pkg::S_FLUSH: begin
                if (slot_free) begin
                    n_ev_v        = 1'b1;
                    n_ev.ovf      = (r_pos > bpts_pkg::POS_W'(bpts_pkg::POS_LIMIT));
                    n_ev.end_step = 1'b1;
                    n_ev.ch       = w_byte[idx];
                    if (r_fill != '0) begin
                        n_ev.kind = bpts_pkg::EV_BYTE;
                        n_ev.pos  = r_pos - bpts_pkg::POS_W'(r_fill);
                        n_fill    = r_fill - 1'b1;
                    end else begin
                        n_ev.kind = bpts_pkg::EV_FINAL;
                        n_ev.pos  = r_pos;
                        n_pos     = '0;
                        n_state   = bpts_pkg::S_RUN;
                    end
                end
            end
            default: begin
                n_state = bpts_pkg::S_RUN;
            end
        endcase
    end

    bpts_piece u_piece (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_valid (r_ev_v),
        .i_ev       (r_ev),
        .i_space_ok (w_space_ok),
        .o_ev_take  (w_ev_take),
        .o_push     (w_push)
    );

    bpts_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_space_ok (w_space_ok),
        .o_valid    (o_piece_valid),
        .i_ready    (i_piece_ready),
        .o_data     (o_piece)
    );

    // The window never holds a full literal's worth of bytes between requests.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= bpts_pkg::FILL_W'(bpts_pkg::WIN_CELLS))
        else $error("window fill out of range");

    // No text is taken while a segment is being flushed.
    a_flush_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bpts_pkg::S_FLUSH |-> !o_text_ready)
        else $error("text accepted during flush");

    // A segment end always starts a flush.
    a_end_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_text.segment_end |=> r_state == bpts_pkg::S_FLUSH)
        else $error("segment end without flush");

    // Closing a segment leaves the position counter cleared.
    a_final_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bpts_pkg::S_FLUSH && r_fill == '0 && (!r_ev_v || w_ev_take)
        |=> r_pos == '0 && r_state == bpts_pkg::S_RUN)
        else $error("segment state not cleared");

endmodule

`default_nettype wire
